@@ rtl/core/bwer_pkg.sv @@
`default_nettype none

package bwer_pkg;

  // field widths fixed by the interface
  localparam int OP_W       = 1;
  localparam int CAT_W      = 4;
  localparam int AMT_W      = 16;
  localparam int TS_W       = 32;
  localparam int WIN_W      = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // defaults for the top-level parameters
  localparam int DEF_NUM_SLOTS      = 128;
  localparam int DEF_SLOT_SECONDS   = 30;
  localparam int DEF_NUM_CATEGORIES = 16;

  // register reset values: ten and twenty minutes
  localparam logic [WIN_W-1:0] WIN_FIRST_RESET  = WIN_W'(600);
  localparam logic [WIN_W-1:0] WIN_SECOND_RESET = WIN_W'(1200);
  localparam logic [CAT_W-1:0] CONN_CAT_RESET   = '0;

  // first category that uses the second default window
  localparam logic [CAT_W-1:0] SECOND_GROUP_FIRST = CAT_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_FIRST  = 2'd0,
    REG_WINDOW_SECOND = 2'd1,
    REG_CONN_CATEGORY = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_RMW,
    ST_WALK,
    ST_LAST
  } state_t;

  // saturating add of two counts
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bwer_div.sv @@
`default_nettype none

// divider by a constant: multiply by a rounded-up reciprocal, then take the
// remainder back from the quotient; done rises when the remainder is registered
module bwer_div import bwer_pkg::*; #(
  parameter int DIVISOR = DEF_SLOT_SECONDS,
  localparam int REM_W  = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [TS_W-1:0]  dividend,
  output logic                  done,
  output logic [TS_W-1:0]       quotient,
  output logic [REM_W-1:0]      remainder
);

  // reciprocal scaled by 2^SHIFT, exact for every 32-bit dividend
  localparam int SHIFT  = TS_W + $clog2(DIVISOR);
  localparam int RCP_W  = TS_W + 1;
  localparam int LO_W   = 17;
  localparam int PART_W = TS_W + LO_W;
  localparam int PROD_W = TS_W + RCP_W;
  localparam longint unsigned RCP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [LO_W-1:0] RCP_LO = LO_W'(RCP);
  localparam logic [LO_W-1:0] RCP_HI = LO_W'(RCP >> LO_W);
  localparam logic [TS_W-1:0] DIV_C  = TS_W'(DIVISOR);

  logic [TS_W-1:0]   x;
  logic [3:0]        phase;
  logic [LO_W-1:0]   coef;
  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] prod;
  logic [TS_W-1:0]   q;
  logic [TS_W-1:0]   diff;
  logic [REM_W-1:0]  rem;

  // one 32x17 product a cycle: low reciprocal half first, then the high half
  always_comb begin
    coef = phase[1] ? RCP_HI : RCP_LO;
    part = {{LO_W{1'b0}}, x} * {{TS_W{1'b0}}, coef};
    diff = x - q * DIV_C;
  end

  // stage sequence after go
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      phase <= {phase[2:0], go};
      done  <= phase[3];
    end
  end

  // product, quotient and remainder stages
  always_ff @(posedge clk) begin
    if (go) begin
      x <= dividend;
    end
    if (phase[0]) begin
      prod <= PROD_W'(part);
    end else if (phase[1]) begin
      prod <= prod + PROD_W'({part, {LO_W{1'b0}}});
    end
    if (phase[2]) begin
      q <= TS_W'(prod >> SHIFT);
    end
    if (phase[3]) begin
      rem <= diff[REM_W-1:0];
    end
  end

  assign quotient  = q;
  assign remainder = rem;

endmodule

`default_nettype wire

@@ rtl/core/bucketed_window_event_rate_unit.sv @@
`default_nettype none

// channel   | signals                                          | direction
// ----------+--------------------------------------------------+----------
// command   | start, busy (out), operation, category, amount,  | in
//           | timestamp, query_window                          |
// result    | done, rate                                       | out
// config    | cfg_valid, cfg_ready (out), cfg_index, cfg_data  | in
//
// A word is taken when start is high and busy is low; one result word follows
// with done high for a single cycle, and the next command may be taken then.
// An add runs two reciprocal divides in turn (stamp and threshold, then slot
// index), the slot update and a one-row-a-cycle walk of the slot memory. A
// query skips the slot steps. After reset busy stays high while the slot memory
// is cleared; cfg_ready is always high and the receiver cannot stall.
module bucketed_window_event_rate_unit import bwer_pkg::*; #(
  parameter int NUM_SLOTS      = DEF_NUM_SLOTS,
  parameter int SLOT_SECONDS   = DEF_SLOT_SECONDS,
  parameter int NUM_CATEGORIES = DEF_NUM_CATEGORIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OP_W-1:0]       operation,
  input  wire logic [CAT_W-1:0]      category,
  input  wire logic [AMT_W-1:0]      amount,
  input  wire logic [TS_W-1:0]       timestamp,
  input  wire logic [WIN_W-1:0]      query_window,
  output logic                       done,
  output logic [CNT_W-1:0]           rate,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam longint unsigned STAMP_MAX = 64'hFFFF_FFFF / SLOT_SECONDS;
  localparam int STAMP_W   = $clog2(STAMP_MAX + 1);
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CAT_IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

  typedef struct packed {
    logic [STAMP_W-1:0]                   stamp;
    logic [NUM_CATEGORIES-1:0][CNT_W-1:0] cnt;
  } row_t;

  // configuration registers
  logic [WIN_W-1:0] window_first;
  logic [WIN_W-1:0] window_second;
  logic [CAT_W-1:0] conn_cat;

  // control and per-command registers
  state_t                state;
  state_t                state_next;
  logic [SLOT_W-1:0]     ptr;
  logic                  rd_pending;
  logic                  is_add;
  logic [CAT_IDX_W-1:0]  cat_idx;
  logic [AMT_W-1:0]      amount_r;
  logic [STAMP_W-1:0]    stamp;
  logic [STAMP_W-1:0]    thr;
  logic                  all_pass;
  logic [SLOT_W-1:0]     slot;
  logic [CNT_W-1:0]      total;

  // slot memory
  row_t                  mem [NUM_SLOTS];
  row_t                  rd_data;
  row_t                  wr_data;
  row_t                  new_row;
  logic                  rd_en;
  logic                  wr_en;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     wr_addr;

  // command decode
  logic                  accept;
  logic                  cat_ok;
  logic [WIN_W-1:0]      def_win;
  logic [WIN_W-1:0]      win_sel;
  logic [TS_W-1:0]       thr_dividend;
  logic [AMT_W-1:0]      amount_eff;

  // fsm outputs
  logic                  div_go;
  logic                  slot_go;
  logic                  ptr_step;
  logic                  ptr_last;

  // divider results
  logic                  stamp_done;
  logic [TS_W-1:0]       stamp_q;
  logic [TS_W-1:0]       thr_q;
  logic                  slot_done;
  logic [SLOT_W-1:0]     slot_rem;

  // walk accumulation
  logic [CNT_W-1:0]      lane;
  logic                  hit;
  logic [CNT_W-1:0]      total_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_first  <= WIN_FIRST_RESET;
      window_second <= WIN_SECOND_RESET;
      conn_cat      <= CONN_CAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WINDOW_FIRST:  window_first  <= cfg_data;
        REG_WINDOW_SECOND: window_second <= cfg_data;
        REG_CONN_CATEGORY: conn_cat      <= cfg_data[CAT_W-1:0];
        default: ;
      endcase
    end
  end

  // category check, window, threshold and effective amount of an incoming command
  always_comb begin
    cat_ok  = 6'(category) < 6'(NUM_CATEGORIES);
    def_win = (category < SECOND_GROUP_FIRST) ? window_first : window_second;
    win_sel = (op_t'(operation) == OP_QUERY && query_window != '0) ? query_window
                                                                   : def_win;
    thr_dividend = timestamp - TS_W'(win_sel);
    amount_eff   = (category == conn_cat && amount == '0) ? AMT_W'(1) : amount;
  end

  // stamp*S + win > now  <=>  win > now, or stamp > (now - win) / S
  bwer_div #(.DIVISOR(SLOT_SECONDS)) u_div_stamp (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (timestamp),
    .done      (stamp_done),
    .quotient  (stamp_q),
    .remainder ()
  );

  bwer_div #(.DIVISOR(SLOT_SECONDS)) u_div_thr (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (thr_dividend),
    .done      (),
    .quotient  (thr_q),
    .remainder ()
  );

  // slot index is the stamp modulo the ring size
  bwer_div #(.DIVISOR(NUM_SLOTS)) u_div_slot (
    .clk       (clk),
    .rst       (rst),
    .go        (slot_go),
    .dividend  (stamp_q),
    .done      (slot_done),
    .quotient  (),
    .remainder (slot_rem)
  );

  assign ptr_last = (ptr == SLOT_W'(NUM_SLOTS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (ptr_last) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = cat_ok ? ST_DIV : ST_LAST;
      ST_DIV:   if (stamp_done) state_next = is_add ? ST_MOD : ST_WALK;
      ST_MOD:   if (slot_done) state_next = ST_RMW;
      ST_RMW:   state_next = ST_WALK;
      ST_WALK:  if (ptr_last) state_next = ST_LAST;
      ST_LAST:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    div_go   = 1'b0;
    slot_go  = 1'b0;
    ptr_step = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = ptr;
    wr_en    = 1'b0;
    wr_addr  = ptr;
    wr_data  = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        ptr_step = 1'b1;
      end
      ST_IDLE:  div_go = accept && cat_ok;
      ST_DIV:   slot_go = stamp_done && is_add;
      ST_MOD: begin
        rd_en   = slot_done;
        rd_addr = slot_rem;
      end
      ST_RMW: begin
        wr_en   = 1'b1;
        wr_addr = slot;
        wr_data = new_row;
      end
      ST_WALK: begin
        rd_en    = 1'b1;
        ptr_step = 1'b1;
      end
      ST_LAST:  ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      ptr        <= '0;
      rd_pending <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= (state == ST_WALK);
      done       <= (state == ST_LAST);
      if (ptr_step) begin
        ptr <= ptr_last ? '0 : ptr + SLOT_W'(1);
      end
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // slot update: restart the bucket on a new stamp, then add
  always_comb begin
    new_row = rd_data;
    if (rd_data.stamp != stamp) begin
      new_row.stamp = stamp;
      new_row.cnt   = '0;
    end
    new_row.cnt[cat_idx] = sat_add(new_row.cnt[cat_idx], CNT_W'(amount_r));
  end

  // walk: add the category's count of every slot inside the window
  always_comb begin
    lane       = rd_data.cnt[cat_idx];
    hit        = all_pass || (rd_data.stamp > thr);
    total_next = sat_add(total, (rd_pending && hit) ? lane : '0);
  end

  // command capture and datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      is_add   <= (op_t'(operation) == OP_ADD);
      cat_idx  <= CAT_IDX_W'(category);
      amount_r <= amount_eff;
      all_pass <= TS_W'(win_sel) > timestamp;
      total    <= '0;
    end else if (rd_pending) begin
      total <= total_next;
    end
    if (state == ST_DIV && stamp_done) begin
      stamp <= STAMP_W'(stamp_q);
      thr   <= STAMP_W'(thr_q);
    end
    if (slot_go == 1'b0 && state == ST_MOD && slot_done) begin
      slot <= slot_rem;
    end
    if (state == ST_LAST) begin
      rate <= total_next;
    end
  end

endmodule

`default_nettype wire
